[rtl/hufhdr_pkg.sv]
// Shared types and constants for the post-order Huffman tree header decoder.
// Used by the front end, back end, top level and checker; depends on nothing.
package hufhdr_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int NODE_LIMIT_DEF  = 511;
    localparam int SYM_BITS        = 8;
    localparam int BIT_Q_DEPTH     = 4;
    localparam int RES_Q_DEPTH     = 2;

    typedef enum logic [1:0] {
        KIND_LEAF = 2'd0,
        KIND_NODE = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef logic [8:0] idx_t;
    typedef logic [7:0] sym_t;

    typedef struct packed {
        logic value;
        logic eob;
    } bit_cmd_t;

    typedef struct packed {
        kind_t kind;
        idx_t  node_index;
        sym_t  symbol;
        idx_t  left_index;
        idx_t  right_index;
        logic  last;
    } result_t;

    typedef enum logic {
        BACK_RUN       = 1'b0,
        BACK_NODE_WAIT = 1'b1
    } back_state_t;

endpackage

[rtl/hufhdr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module hufhdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hufhdr_fifo.sv]
// Small register FIFO with a combinational head read.
// Depends on nothing.
module hufhdr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_reg;
    logic [AW-1:0]    wr_next;
    logic [AW-1:0]    rd_reg;
    logic [AW-1:0]    rd_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        full     = (cnt_reg == CW'(DEPTH));
        empty    = (cnt_reg == '0);
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_data = data_reg[rd_reg];
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_reg] <= push_data;
        end
    end

endmodule

[rtl/hufhdr_front.sv]
// Front end: takes header words and splits each into bit commands, MSB first.
// Depends on hufhdr_pkg.
module hufhdr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          header_byte,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output hufhdr_pkg::bit_cmd_t cmd
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;
    logic       take;

    always_comb
    begin
        cmd_valid = (left_reg != '0);
        cmd.value = byte_reg[7];
        cmd.eob   = (left_reg == 4'd1);
        in_ready  = (left_reg == '0) || ((left_reg == 4'd1) && cmd_ready);
        take      = in_valid && in_ready;
        byte_next = byte_reg;
        left_next = left_reg;
        if (take)
        begin
            byte_next = header_byte;
            left_next = 4'(hufhdr_pkg::SYM_BITS);
        end
        else if (cmd_valid && cmd_ready)
        begin
            byte_next = {byte_reg[6:0], 1'b0};
            left_next = left_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

[rtl/hufhdr_back.sv]
// Back end: executes bit commands against the node stack and forms result words.
// Depends on hufhdr_pkg and hufhdr_ram.
module hufhdr_back #(
    parameter int STACK_DEPTH = hufhdr_pkg::STACK_DEPTH_DEF,
    parameter int NODE_LIMIT  = hufhdr_pkg::NODE_LIMIT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  hufhdr_pkg::bit_cmd_t cmd,
    output logic                 res_valid,
    input  logic                 res_ready,
    output hufhdr_pkg::result_t  res_data
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = $clog2(NODE_LIMIT + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    hufhdr_pkg::back_state_t state_reg;
    hufhdr_pkg::back_state_t state_next;
    logic [DW-1:0]           depth_reg;
    logic [DW-1:0]           depth_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [CW-1:0]           tos_reg;
    logic [CW-1:0]           tos_next;
    logic [7:0]              acc_reg;
    logic [7:0]              acc_next;
    logic [3:0]              pend_reg;
    logic [3:0]              pend_next;
    logic                    drop_reg;
    logic                    drop_next;
    logic                    hold_v_reg;
    logic                    hold_v_next;
    hufhdr_pkg::result_t     hold_reg;
    hufhdr_pkg::result_t     hold_next;

    hufhdr_pkg::result_t     r;
    logic                    r_v;
    logic                    stop;
    logic                    go_wait;
    logic                    take;
    logic                    full_stack;
    logic                    full_nodes;
    logic [7:0]              sym_shift;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [CW-1:0]           ram_rdata;

    hufhdr_ram #(
        .WIDTH(CW),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(tos_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        count_next  = count_reg;
        tos_next    = tos_reg;
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        drop_next   = drop_reg;
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;
        res_data    = hold_reg;
        ram_we      = 1'b0;
        ram_waddr   = AW'(depth_reg - DW'(1));
        ram_raddr   = AW'(depth_reg - DW'(2));
        r           = '0;
        r_v         = 1'b0;
        stop        = 1'b0;
        go_wait     = 1'b0;
        take        = 1'b0;
        full_stack  = (depth_reg >= DW'(STACK_DEPTH));
        full_nodes  = (count_reg >= CW'(NODE_LIMIT));
        sym_shift   = {acc_reg[6:0], cmd.value};

        // Classify the command at the head of the queue.
        if (state_reg == hufhdr_pkg::BACK_NODE_WAIT)
        begin
            r_v           = 1'b1;
            r.kind        = hufhdr_pkg::KIND_NODE;
            r.node_index  = hufhdr_pkg::idx_t'(count_reg);
            r.left_index  = hufhdr_pkg::idx_t'(ram_rdata);
            r.right_index = hufhdr_pkg::idx_t'(tos_reg);
        end
        else if (pend_reg != '0)
        begin
            if (pend_reg == 4'd1)
            begin
                r_v = 1'b1;
                if (full_stack || full_nodes)
                begin
                    r.kind = hufhdr_pkg::KIND_ERR;
                    stop   = 1'b1;
                end
                else
                begin
                    r.kind       = hufhdr_pkg::KIND_LEAF;
                    r.node_index = hufhdr_pkg::idx_t'(count_reg);
                    r.symbol     = sym_shift;
                end
            end
        end
        else if (!cmd.value)
        begin
            if (depth_reg == '0)
            begin
                r_v    = 1'b1;
                r.kind = hufhdr_pkg::KIND_ERR;
                stop   = 1'b1;
            end
            else if (depth_reg == DW'(1))
            begin
                r_v          = 1'b1;
                r.kind       = hufhdr_pkg::KIND_DONE;
                r.node_index = hufhdr_pkg::idx_t'(tos_reg);
                stop         = 1'b1;
            end
            else if (full_nodes)
            begin
                r_v    = 1'b1;
                r.kind = hufhdr_pkg::KIND_ERR;
                stop   = 1'b1;
            end
            else
            begin
                go_wait = 1'b1;
            end
        end

        // A held word marked last leaves before any further command.
        if (hold_v_reg && hold_reg.last)
        begin
            res_valid = 1'b1;
            if (res_ready)
            begin
                hold_v_next = 1'b0;
            end
        end
        else if (cmd_valid)
        begin
            if (drop_reg)
            begin
                cmd_ready = 1'b1;
                if (cmd.eob)
                begin
                    drop_next      = 1'b0;
                    hold_next.last = 1'b1;
                end
            end
            else if (go_wait)
            begin
                state_next = hufhdr_pkg::BACK_NODE_WAIT;
            end
            else if (r_v)
            begin
                if (!hold_v_reg || res_ready)
                begin
                    cmd_ready      = 1'b1;
                    take           = 1'b1;
                    res_valid      = hold_v_reg;
                    hold_next      = r;
                    hold_next.last = cmd.eob;
                    hold_v_next    = 1'b1;
                end
            end
            else
            begin
                cmd_ready = 1'b1;
                take      = 1'b1;
                if (cmd.eob && hold_v_reg)
                begin
                    hold_next.last = 1'b1;
                end
            end
        end

        // Apply the state change of a consumed command.
        if (take)
        begin
            if (stop)
            begin
                depth_next = '0;
                count_next = '0;
                acc_next   = '0;
                pend_next  = '0;
                drop_next  = !cmd.eob;
            end
            else if (state_reg == hufhdr_pkg::BACK_NODE_WAIT)
            begin
                tos_next   = count_reg;
                count_next = count_reg + CW'(1);
                depth_next = depth_reg - DW'(1);
                state_next = hufhdr_pkg::BACK_RUN;
            end
            else if (pend_reg != '0)
            begin
                acc_next  = sym_shift;
                pend_next = pend_reg - 4'd1;
                if (pend_reg == 4'd1)
                begin
                    ram_we     = (depth_reg != '0);
                    tos_next   = count_reg;
                    count_next = count_reg + CW'(1);
                    depth_next = depth_reg + DW'(1);
                    acc_next   = '0;
                end
            end
            else if (cmd.value)
            begin
                pend_next = 4'(hufhdr_pkg::SYM_BITS);
                acc_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hufhdr_pkg::BACK_RUN;
            depth_reg  <= '0;
            count_reg  <= '0;
            tos_reg    <= '0;
            acc_reg    <= '0;
            pend_reg   <= '0;
            drop_reg   <= 1'b0;
            hold_v_reg <= 1'b0;
            hold_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            count_reg  <= count_next;
            tos_reg    <= tos_next;
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            drop_reg   <= drop_next;
            hold_v_reg <= hold_v_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

[rtl/huffman_bit_header_tree_builder.sv]
// Top level of the post-order Huffman tree header decoder.
// Depends on hufhdr_pkg, hufhdr_fifo, hufhdr_front and hufhdr_back.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+--------------------------------------------
//   input   | in_valid, in_ready  | header_byte
//   output  | out_valid, out_ready| kind, node_index, symbol, left_index,
//           |                     | right_index, last
//
// Each header word is split into eight bits, which enter a four-entry bit
// queue one per cycle while it has room. The back end takes the bits in order;
// an internal node passes through BACK_NODE_WAIT because the left child comes
// from the stack RAM's registered read port, and a word flagged last is
// released before any further bit is taken.
// Reset clears all control state; the stack RAM needs no clearing pass.
// A stalled output fills a two-entry result queue and then holds the back end.
module huffman_bit_header_tree_builder #(
    parameter int STACK_DEPTH = hufhdr_pkg::STACK_DEPTH_DEF,
    parameter int NODE_LIMIT  = hufhdr_pkg::NODE_LIMIT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] header_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [8:0] node_index,
    output logic [7:0] symbol,
    output logic [8:0] left_index,
    output logic [8:0] right_index,
    output logic       last
);

    hufhdr_pkg::bit_cmd_t fe_cmd;
    hufhdr_pkg::bit_cmd_t be_cmd;
    hufhdr_pkg::result_t  be_res;
    hufhdr_pkg::result_t  out_res;
    logic                 fe_valid;
    logic                 bq_full;
    logic                 bq_empty;
    logic                 be_cmd_ready;
    logic                 be_res_valid;
    logic                 rq_full;
    logic                 rq_empty;

    hufhdr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .header_byte(header_byte),
        .cmd_valid  (fe_valid),
        .cmd_ready  (!bq_full),
        .cmd        (fe_cmd)
    );

    hufhdr_fifo #(
        .WIDTH($bits(hufhdr_pkg::bit_cmd_t)),
        .DEPTH(hufhdr_pkg::BIT_Q_DEPTH)
    ) u_bit_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fe_valid),
        .push_data(fe_cmd),
        .full     (bq_full),
        .pop      (be_cmd_ready),
        .pop_data (be_cmd),
        .empty    (bq_empty)
    );

    hufhdr_back #(
        .STACK_DEPTH(STACK_DEPTH),
        .NODE_LIMIT (NODE_LIMIT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(!bq_empty),
        .cmd_ready(be_cmd_ready),
        .cmd      (be_cmd),
        .res_valid(be_res_valid),
        .res_ready(!rq_full),
        .res_data (be_res)
    );

    hufhdr_fifo #(
        .WIDTH($bits(hufhdr_pkg::result_t)),
        .DEPTH(hufhdr_pkg::RES_Q_DEPTH)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (be_res_valid),
        .push_data(be_res),
        .full     (rq_full),
        .pop      (out_ready),
        .pop_data (out_res),
        .empty    (rq_empty)
    );

    assign out_valid   = !rq_empty;
    assign kind        = out_res.kind;
    assign node_index  = out_res.node_index;
    assign symbol      = out_res.symbol;
    assign left_index  = out_res.left_index;
    assign right_index = out_res.right_index;
    assign last        = out_res.last;

    a_word_takes_bits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("front end accepted a word while still splitting one");

    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == hufhdr_pkg::KIND_ERR) |->
            (node_index == '0) && (symbol == '0) && (left_index == '0) &&
            (right_index == '0))
        else $error("error word carries nonzero fields");

    a_children_only_nodes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != hufhdr_pkg::KIND_NODE) |->
            (left_index == '0) && (right_index == '0))
        else $error("child indices on a word that is not an internal node");

    a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        be_res_valid && rq_full |=> be_res_valid)
        else $error("back end let go of a result word the queue refused");

endmodule

[sim/hufhdr_tree_checker.sv]
`timescale 1ns / 1ps
// Checker for the post-order Huffman tree header decoder: watches both channels,
// predicts every node word from the accepted header words and compares them.
// Depends on hufhdr_pkg.
module hufhdr_tree_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] header_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] kind,
    input  logic [8:0] node_index,
    input  logic [7:0] symbol,
    input  logic [8:0] left_index,
    input  logic [8:0] right_index,
    input  logic       last,
    output int         mismatches,
    output int         pending
);

    hufhdr_pkg::idx_t    open_nodes [hufhdr_pkg::STACK_DEPTH_DEF];
    int                  open_count   = 0;
    hufhdr_pkg::sym_t    symbol_shift = '0;
    int                  symbol_left  = 0;
    int                  nodes_built  = 0;
    hufhdr_pkg::result_t expected_nodes [$];

    function automatic void clear_tree();
        open_count   = 0;
        symbol_shift = '0;
        symbol_left  = 0;
        nodes_built  = 0;
    endfunction

    function automatic void decode_header_word(input logic [7:0] w);
        hufhdr_pkg::result_t words [$];
        hufhdr_pkg::result_t r;
        hufhdr_pkg::idx_t    top_node;
        hufhdr_pkg::idx_t    below_node;
        bit                  quit;
        quit = 1'b0;
        for (int b = 7; b >= 0 && !quit; b--)
        begin
            r = '0;
            if (symbol_left != 0)
            begin
                symbol_shift = {symbol_shift[6:0], w[b]};
                symbol_left--;
                if (symbol_left == 0)
                begin
                    if (open_count >= hufhdr_pkg::STACK_DEPTH_DEF ||
                        nodes_built >= hufhdr_pkg::NODE_LIMIT_DEF)
                    begin
                        r.kind = hufhdr_pkg::KIND_ERR;
                        quit = 1'b1;
                    end
                    else
                    begin
                        open_nodes[open_count] = hufhdr_pkg::idx_t'(nodes_built);
                        open_count++;
                        r.kind = hufhdr_pkg::KIND_LEAF;
                        r.node_index = hufhdr_pkg::idx_t'(nodes_built);
                        r.symbol = symbol_shift;
                        nodes_built++;
                        symbol_shift = '0;
                    end
                    words.push_back(r);
                end
            end
            else if (w[b])
            begin
                symbol_left = hufhdr_pkg::SYM_BITS;
                symbol_shift = '0;
            end
            else if (open_count == 0)
            begin
                r.kind = hufhdr_pkg::KIND_ERR;
                quit = 1'b1;
                words.push_back(r);
            end
            else
            begin
                open_count--;
                top_node = open_nodes[open_count];
                if (open_count == 0)
                begin
                    r.kind = hufhdr_pkg::KIND_DONE;
                    r.node_index = top_node;
                    quit = 1'b1;
                end
                else if (nodes_built >= hufhdr_pkg::NODE_LIMIT_DEF)
                begin
                    r.kind = hufhdr_pkg::KIND_ERR;
                    quit = 1'b1;
                end
                else
                begin
                    open_count--;
                    below_node = open_nodes[open_count];
                    open_nodes[open_count] = hufhdr_pkg::idx_t'(nodes_built);
                    open_count++;
                    r.kind = hufhdr_pkg::KIND_NODE;
                    r.node_index = hufhdr_pkg::idx_t'(nodes_built);
                    r.left_index = below_node;
                    r.right_index = top_node;
                    nodes_built++;
                end
                words.push_back(r);
            end
        end
        if (quit)
            clear_tree();
        if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
        foreach (words[i])
            expected_nodes.push_back(words[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hufhdr_pkg::result_t want;
        hufhdr_pkg::result_t got;
        if (!rst_n)
        begin
            clear_tree();
            expected_nodes.delete();
            mismatches = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_header_word(header_byte);
            if (out_valid && out_ready)
            begin
                got = '0;
                got.kind = hufhdr_pkg::kind_t'(kind);
                got.node_index = node_index;
                got.symbol = symbol;
                got.left_index = left_index;
                got.right_index = right_index;
                got.last = last;
                if (expected_nodes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected node word: kind %0d index %0d symbol %0h %s%0d %s%0d %s%0d",
                                 kind, node_index, symbol, "left ", left_index,
                                 "right ", right_index, "last ", last);
                end
                else
                begin
                    want = expected_nodes.pop_front();
                    if (got.kind !== want.kind || got.node_index !== want.node_index ||
                        got.symbol !== want.symbol || got.left_index !== want.left_index ||
                        got.right_index !== want.right_index || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Node word mismatch, expected: kind %0d index %0d symbol %0h",
                                     want.kind, want.node_index, want.symbol);
                            $display("    left %0d right %0d last %0d",
                                     want.left_index, want.right_index, want.last);
                            $display("  got: kind %0d index %0d symbol %0h",
                                     kind, node_index, symbol);
                            $display("    left %0d right %0d last %0d",
                                     left_index, right_index, last);
                        end
                    end
                end
            end
        end
        pending = expected_nodes.size();
    end

endmodule

[sim/tb_huffman_bit_header_tree_builder.sv]
`timescale 1ns / 1ps
// Top of the testbench for the post-order Huffman tree header decoder: makes the
// header words and the output stalls, and gives the verdict. Depends on
// hufhdr_tree_checker and the block itself.
module tb_huffman_bit_header_tree_builder;

    localparam int CYCLE_LIMIT     = 900000;
    localparam int OUT_HOLD_CYCLES = 400;
    localparam int RANDOM_WORDS    = 130;
    localparam int TAIL_CYCLES     = 60;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] header_byte = 8'h00;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [1:0] kind;
    logic [8:0] node_index;
    logic [7:0] symbol;
    logic [8:0] left_index;
    logic [8:0] right_index;
    logic       last;

    int mismatch_total;
    int pending_words;
    int words_sent  = 0;
    bit quick_send  = 1'b0;
    bit hold_output = 1'b0;
    bit header_bits [$];

    huffman_bit_header_tree_builder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .header_byte (header_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .node_index  (node_index),
        .symbol      (symbol),
        .left_index  (left_index),
        .right_index (right_index),
        .last        (last)
    );

    hufhdr_tree_checker tree_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .header_byte (header_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .node_index  (node_index),
        .symbol      (symbol),
        .left_index  (left_index),
        .right_index (right_index),
        .last        (last),
        .mismatches  (mismatch_total),
        .pending     (pending_words)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int gap;
        int quick_left;
        int hold_count;
        bit held;
        quick_left = 0;
        held = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_output && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < OUT_HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_count++;
                end
            end
            if (quick_left > 0)
            begin
                gap = 0;
                quick_left--;
            end
            else
            begin
                gap = $urandom_range(0, 9);
                if ($urandom_range(0, 15) == 0)
                    quick_left = 30;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_word(input logic [7:0] w);
        int gap;
        gap = quick_send ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        header_byte <= w;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic queue_leaf(input logic [7:0] sym);
        header_bits.push_back(1'b1);
        for (int i = 7; i >= 0; i--)
            header_bits.push_back(sym[i]);
    endtask

    task automatic queue_join();
        header_bits.push_back(1'b0);
    endtask

    task automatic queue_tree(input int leaves);
        int open;
        int left;
        open = 0;
        left = leaves;
        while (left > 0 || open > 1)
        begin
            if (left > 0 && (open < 2 || $urandom_range(0, 1) == 1))
            begin
                queue_leaf(8'($urandom_range(0, 255)));
                left--;
                open++;
            end
            else
            begin
                queue_join();
                open--;
            end
        end
        queue_join();
    endtask

    task automatic flush_header();
        logic [7:0] w;
        w = '0;
        while (header_bits.size() > 0)
        begin
            for (int i = 0; i < 8; i++)
                w = {w[6:0], (header_bits.size() > 0) ? header_bits.pop_front()
                                                      : 1'($urandom_range(0, 1))};
            send_word(w);
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
    endtask

    task automatic send_zero_words(input int count);
        repeat (count) send_word(8'h00);
    endtask

    initial
    begin
        int goal;
        int leaves;
        int pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(8'h00);
        queue_leaf(8'h00);
        queue_leaf(8'hFF);
        queue_join();
        queue_join();
        flush_header();
        send_word(8'hFF);
        send_word(8'h80);
        queue_leaf(8'h5A);
        queue_join();
        flush_header();
        queue_leaf(8'h01);
        queue_leaf(8'h80);
        queue_leaf(8'h7F);
        queue_join();
        queue_join();
        queue_leaf(8'hFE);
        queue_join();
        queue_join();
        flush_header();
        for (int i = 0; i < 8; i++)
            queue_leaf(8'(17 * i));
        flush_header();
        send_word(8'h00);
        wait_for_drain();

        hold_output = 1'b1;
        quick_send = 1'b1;
        queue_tree(20);
        flush_header();
        quick_send = 1'b0;
        wait_for_drain();

        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal)
        begin
            quick_send = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 19);
            leaves = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            if (pick < 14)
            begin
                queue_tree(leaves);
                flush_header();
            end
            else if (pick < 17)
            begin
                queue_tree(leaves);
                repeat ($urandom_range(1, header_bits.size() - 1))
                    void'(header_bits.pop_back());
                flush_header();
                send_zero_words(3);
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)));
                send_zero_words(3);
            end
            if ($urandom_range(0, 9) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && pending_words == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[huffman_bit_header_tree_builder.f]
rtl/hufhdr_pkg.sv
rtl/hufhdr_ram.sv
rtl/hufhdr_fifo.sv
rtl/hufhdr_front.sv
rtl/hufhdr_back.sv
rtl/huffman_bit_header_tree_builder.sv
sim/hufhdr_tree_checker.sv
sim/tb_huffman_bit_header_tree_builder.sv
